// ===== sv/sdi_pkg.sv =====
`default_nettype none

package sdi_pkg;

  // Sequencer phases, one-hot.
  typedef enum logic [16:0] {
    PH_IDLE    = 17'h00001,
    PH_DESEL_A = 17'h00002,
    PH_DESEL_B = 17'h00004,
    PH_WAKE    = 17'h00008,
    PH_SEL_A   = 17'h00010,
    PH_SEL_B   = 17'h00020,
    PH_BUSY    = 17'h00040,
    PH_SEND    = 17'h00080,
    PH_R1      = 17'h00100,
    PH_DATA8   = 17'h00200,
    PH_DATA58  = 17'h00400,
    PH_OK_A    = 17'h00800,
    PH_OK_B    = 17'h01000,
    PH_FAIL_A  = 17'h02000,
    PH_FAIL_B  = 17'h04000,
    PH_DONE    = 17'h08000,
    PH_FAILED  = 17'h10000
  } phase_t;

  // Command currently being issued.
  typedef enum logic [2:0] {
    CMD_GO_IDLE  = 3'd0,
    CMD_IF_COND  = 3'd1,
    CMD_APP      = 3'd2,
    CMD_OP_COND  = 3'd3,
    CMD_READ_OCR = 3'd4
  } cmd_t;

  // Failure step codes.
  localparam logic [2:0] FAIL_CMD0   = 3'd0;
  localparam logic [2:0] FAIL_CMD8   = 3'd1;
  localparam logic [2:0] FAIL_ECHO   = 3'd2;
  localparam logic [2:0] FAIL_CMD55  = 3'd3;
  localparam logic [2:0] FAIL_ACMD41 = 3'd4;
  localparam logic [2:0] FAIL_CMD58  = 3'd5;
  localparam logic [2:0] FAIL_OCR    = 3'd6;

  localparam logic [7:0] CMD_LEN     = 8'd6;
  localparam logic [7:0] BYTE_IDLE   = 8'hFF;
  localparam logic [7:0] R1_IDLE     = 8'h01;
  localparam logic [7:0] R1_READY    = 8'h00;
  localparam logic [7:0] ECHO_PATT   = 8'hAA;
  localparam logic [7:0] OCR_MASK    = 8'hC0;
  localparam logic [7:0] DATA8_LAST  = 8'd3;
  localparam logic [7:0] DATA8_ECHO  = 8'd2;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic       exchange;
    logic [7:0] tx_byte;
    logic       chip_select_n;
    logic       done_res;
    logic       failed;
    logic [2:0] fail_step;
  } res_t;

  // Six-byte command frames (index, argument, CRC).
  function automatic logic [7:0] cmd_byte(input cmd_t cmd, input logic [2:0] idx);
    logic [7:0] b;
    b = BYTE_IDLE;
    unique case (idx)
      3'd0: begin
        unique case (cmd)
          CMD_GO_IDLE:  b = 8'h40;
          CMD_IF_COND:  b = 8'h48;
          CMD_APP:      b = 8'h77;
          CMD_OP_COND:  b = 8'h69;
          default:      b = 8'h7A;
        endcase
      end
      3'd1:    b = (cmd == CMD_OP_COND) ? 8'h40 : 8'h00;
      3'd2:    b = 8'h00;
      3'd3:    b = (cmd == CMD_IF_COND) ? 8'h01 : 8'h00;
      3'd4:    b = (cmd == CMD_IF_COND) ? ECHO_PATT : 8'h00;
      3'd5: begin
        unique case (cmd)
          CMD_GO_IDLE: b = 8'h95;
          CMD_IF_COND: b = 8'h87;
          default:     b = 8'hFF;
        endcase
      end
      default: b = BYTE_IDLE;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== sv/sdi_seq.sv =====
`default_nettype none

// Sequencer state and per-request next-state / result logic.
module sdi_seq (
  input  wire              clk,
  input  wire              rst,
  input  wire              step,
  input  sdi_pkg::req_t    req,
  input  wire  [7:0]       wakeup_bytes,
  output sdi_pkg::res_t    res
);

  sdi_pkg::phase_t phase, phase_next;
  sdi_pkg::cmd_t   cmd, cmd_next;
  logic [7:0]      byte_count, byte_count_next;
  logic            echo_ok, echo_ok_next;
  logic [2:0]      fail_code, fail_code_next;
  logic [7:0]      bc_inc;
  logic [7:0]      rx;

  assign bc_inc = byte_count + 8'd1;
  assign rx     = req.rx_byte;

  always_comb begin
    phase_next      = phase;
    cmd_next        = cmd;
    byte_count_next = byte_count;
    echo_ok_next    = echo_ok;
    fail_code_next  = fail_code;
    if (!req.opcode) begin
      phase_next      = sdi_pkg::PH_DESEL_A;
      byte_count_next = 8'd0;
      echo_ok_next    = 1'b0;
      fail_code_next  = sdi_pkg::FAIL_CMD0;
    end else begin
      unique case (phase)
        sdi_pkg::PH_DESEL_A: phase_next = sdi_pkg::PH_DESEL_B;
        sdi_pkg::PH_DESEL_B: begin
          byte_count_next = 8'd0;
          phase_next = (wakeup_bytes == 8'd0) ? sdi_pkg::PH_SEL_A : sdi_pkg::PH_WAKE;
        end
        sdi_pkg::PH_WAKE: begin
          byte_count_next = bc_inc;
          if (bc_inc >= wakeup_bytes) phase_next = sdi_pkg::PH_SEL_A;
        end
        sdi_pkg::PH_SEL_A: phase_next = sdi_pkg::PH_SEL_B;
        sdi_pkg::PH_SEL_B: begin
          phase_next = sdi_pkg::PH_BUSY;
          cmd_next   = sdi_pkg::CMD_GO_IDLE;
        end
        sdi_pkg::PH_BUSY: begin
          if (rx == sdi_pkg::BYTE_IDLE) begin
            phase_next      = sdi_pkg::PH_SEND;
            byte_count_next = 8'd0;
          end
        end
        sdi_pkg::PH_SEND: begin
          byte_count_next = bc_inc;
          if (bc_inc >= sdi_pkg::CMD_LEN) phase_next = sdi_pkg::PH_R1;
        end
        sdi_pkg::PH_R1: begin
          // wait for R1 (bit 7 clear)
          if (!rx[7]) begin
            unique case (cmd)
              sdi_pkg::CMD_GO_IDLE: begin
                if (rx == sdi_pkg::R1_IDLE) begin
                  phase_next = sdi_pkg::PH_BUSY;
                  cmd_next   = sdi_pkg::CMD_IF_COND;
                end else begin
                  phase_next     = sdi_pkg::PH_FAIL_A;
                  fail_code_next = sdi_pkg::FAIL_CMD0;
                end
              end
              sdi_pkg::CMD_IF_COND: begin
                if (rx == sdi_pkg::R1_IDLE) begin
                  phase_next      = sdi_pkg::PH_DATA8;
                  byte_count_next = 8'd0;
                  echo_ok_next    = 1'b0;
                end else begin
                  phase_next     = sdi_pkg::PH_FAIL_A;
                  fail_code_next = sdi_pkg::FAIL_CMD8;
                end
              end
              sdi_pkg::CMD_APP: begin
                if (rx == sdi_pkg::R1_IDLE) begin
                  phase_next = sdi_pkg::PH_BUSY;
                  cmd_next   = sdi_pkg::CMD_OP_COND;
                end else begin
                  phase_next     = sdi_pkg::PH_FAIL_A;
                  fail_code_next = sdi_pkg::FAIL_CMD55;
                end
              end
              sdi_pkg::CMD_OP_COND: begin
                if (rx == sdi_pkg::R1_READY) begin
                  phase_next = sdi_pkg::PH_BUSY;
                  cmd_next   = sdi_pkg::CMD_READ_OCR;
                end else if (rx == sdi_pkg::R1_IDLE) begin
                  phase_next = sdi_pkg::PH_BUSY;
                  cmd_next   = sdi_pkg::CMD_APP;
                end else begin
                  phase_next     = sdi_pkg::PH_FAIL_A;
                  fail_code_next = sdi_pkg::FAIL_ACMD41;
                end
              end
              default: begin
                if (rx == sdi_pkg::R1_READY) begin
                  phase_next      = sdi_pkg::PH_DATA58;
                  byte_count_next = 8'd0;
                  echo_ok_next    = 1'b0;
                end else begin
                  phase_next     = sdi_pkg::PH_FAIL_A;
                  fail_code_next = sdi_pkg::FAIL_CMD58;
                end
              end
            endcase
          end
        end
        sdi_pkg::PH_DATA8: begin
          if (byte_count == sdi_pkg::DATA8_ECHO) echo_ok_next = rx[0];
          if (byte_count >= sdi_pkg::DATA8_LAST) begin
            if (echo_ok && rx == sdi_pkg::ECHO_PATT) begin
              phase_next = sdi_pkg::PH_BUSY;
              cmd_next   = sdi_pkg::CMD_APP;
            end else begin
              phase_next     = sdi_pkg::PH_FAIL_A;
              fail_code_next = sdi_pkg::FAIL_ECHO;
            end
          end else begin
            byte_count_next = bc_inc;
          end
        end
        sdi_pkg::PH_DATA58: begin
          if (byte_count == 8'd0)
            echo_ok_next = ((rx & sdi_pkg::OCR_MASK) == sdi_pkg::OCR_MASK);
          if (byte_count >= sdi_pkg::DATA8_LAST) begin
            if (echo_ok) begin
              phase_next = sdi_pkg::PH_OK_A;
            end else begin
              phase_next     = sdi_pkg::PH_FAIL_A;
              fail_code_next = sdi_pkg::FAIL_OCR;
            end
          end else begin
            byte_count_next = bc_inc;
          end
        end
        sdi_pkg::PH_OK_A:   phase_next = sdi_pkg::PH_OK_B;
        sdi_pkg::PH_OK_B:   phase_next = sdi_pkg::PH_DONE;
        sdi_pkg::PH_FAIL_A: phase_next = sdi_pkg::PH_FAIL_B;
        sdi_pkg::PH_FAIL_B: phase_next = sdi_pkg::PH_FAILED;
        default:            phase_next = phase;
      endcase
    end
  end

  // Result reflects the state after this request.
  always_comb begin
    res.exchange      = 1'b1;
    res.tx_byte       = sdi_pkg::BYTE_IDLE;
    res.chip_select_n = 1'b0;
    res.done_res      = 1'b0;
    res.failed        = 1'b0;
    res.fail_step     = 3'd0;
    unique case (phase_next)
      sdi_pkg::PH_IDLE, sdi_pkg::PH_DONE, sdi_pkg::PH_FAILED: begin
        res.exchange      = 1'b0;
        res.tx_byte       = 8'h00;
        res.chip_select_n = 1'b1;
        res.done_res      = (phase_next == sdi_pkg::PH_DONE);
        res.failed        = (phase_next == sdi_pkg::PH_FAILED);
        res.fail_step     = (phase_next == sdi_pkg::PH_FAILED) ? fail_code_next : 3'd0;
      end
      sdi_pkg::PH_DESEL_A, sdi_pkg::PH_DESEL_B, sdi_pkg::PH_WAKE, sdi_pkg::PH_SEL_A,
      sdi_pkg::PH_OK_B, sdi_pkg::PH_FAIL_B: begin
        res.chip_select_n = 1'b1;
      end
      sdi_pkg::PH_SEND: begin
        res.tx_byte = sdi_pkg::cmd_byte(cmd_next, byte_count_next[2:0]);
      end
      default: begin
        res.chip_select_n = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= sdi_pkg::PH_IDLE;
      cmd        <= sdi_pkg::CMD_GO_IDLE;
      byte_count <= 8'd0;
      echo_ok    <= 1'b0;
      fail_code  <= 3'd0;
    end else if (step) begin
      phase      <= phase_next;
      cmd        <= cmd_next;
      byte_count <= byte_count_next;
      echo_ok    <= echo_ok_next;
      fail_code  <= fail_code_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sd_spi_init_sequencer_core.sv =====
`default_nettype none

// SD card SPI-mode start-up sequencer. Each input request is either a start
// (tuser = 0) or the report of a finished byte exchange (tuser = 1, tdata =
// received byte); each request yields exactly one result that tells the SPI
// engine whether to run another exchange, which byte to send and the chip
// select level to use, or reports done / failed with the failing step
// (0 CMD0, 1 CMD8, 2 R7 echo, 3 CMD55, 4 ACMD41, 5 CMD58, 6 OCR). The flow is:
// deselect, wakeup_bytes bytes of 0xFF, select, CMD0, CMD8 with echo check,
// CMD55/ACMD41 until ready, CMD58 with OCR check. A start always restarts.
// Timing: a request goes into an input register, the decision is made by
// combinational logic and lands in the output register. One request per
// clock is sustained while m_axis_tready is high; the output register lets a
// new request enter while a result still waits.
// The wake-up count register may only be written while no request is in flight.
module sd_spi_init_sequencer_core (
  input  wire         clk,
  input  wire         rst,
  // config: wake-up byte count
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [7:0]  cfg_data,
  // request stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire  [0:0]  s_axis_tuser,   // [0] opcode
  // result stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata    // [0] exchange, [8:1] tx_byte,
                                      // [9] chip_select_n, [10] done_res,
                                      // [11] failed, [14:12] fail_step, [15] 0
);

  logic          in_valid;
  sdi_pkg::req_t in_req;
  logic          out_valid;
  sdi_pkg::res_t out_res;
  sdi_pkg::res_t res;
  logic          advance;
  logic [7:0]    wakeup_bytes;

  // move input stage into result stage
  assign advance       = in_valid & (~out_valid | m_axis_tready);
  assign s_axis_tready = ~in_valid | advance;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wakeup_bytes <= 8'd10;
    end else if (cfg_valid) begin
      wakeup_bytes <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req.opcode  <= s_axis_tuser[0];
      in_req.rx_byte <= s_axis_tdata;
    end
  end

  sdi_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .req          (in_req),
    .wakeup_bytes (wakeup_bytes),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_res.fail_step, out_res.failed, out_res.done_res,
                          out_res.chip_select_n, out_res.tx_byte, out_res.exchange};

endmodule

`default_nettype wire
